// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of the ultrasonic ranger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, sampled on i_clk and disabled while reset is held.
`define UPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Once cond holds, sig keeps its value into the next cycle.
`define UPR_ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

// ----- src/upr_pkg.sv -----
// Types, constants and register codes of the ultrasonic ranger.
package upr_pkg;

    localparam int COUNT_WIDTH = 15;
    localparam int CNT_MAX     = (1 << COUNT_WIDTH) - 1;

    localparam int TRIG_W    = 8;
    localparam int HOLD_W    = 12;
    localparam int TIMEOUT_W = 15;
    localparam int DIST_W    = 16;
    localparam int WIDTH_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Result word bit positions
    localparam int OB_DRIVE    = 0;
    localparam int OB_OE       = 1;
    localparam int OB_BUSY     = 2;
    localparam int OB_VALID    = 3;
    localparam int OB_WIDTH_LO = 4;
    localparam int OB_DIST_LO  = OB_WIDTH_LO + WIDTH_W;
    localparam int OB_NEAR     = OB_DIST_LO + DIST_W;
    localparam int OB_TOUT     = OB_NEAR + 1;
    localparam int OB_PAD_W    = OUT_TDATA_W - OB_TOUT - 1;

    // Distance scale: 0.034 cm/us * 64 in Q10
    localparam int DIST_MULT   = 2228;
    localparam int DIST_MULT_W = 12;
    localparam int DIST_SHIFT  = 10;
    localparam int PROD_W      = (WIDTH_W - 1) + DIST_MULT_W;

    localparam logic [TRIG_W-1:0]    RST_TRIG_LOW  = TRIG_W'(2);
    localparam logic [TRIG_W-1:0]    RST_TRIG_HIGH = TRIG_W'(5);
    localparam logic [HOLD_W-1:0]    RST_HOLDOFF   = HOLD_W'(750);
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT   = TIMEOUT_W'(18500);
    localparam logic [DIST_W-1:0]    RST_NEAR_THR  = DIST_W'(1440);

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [WIDTH_W-1:0]     t_width;
    typedef logic [DIST_W-1:0]      t_dist;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRELOW,
        PH_HIGH,
        PH_HOLD,
        PH_ECHO
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIG_LOW,
        CFG_TRIG_HIGH,
        CFG_HOLDOFF,
        CFG_TIMEOUT,
        CFG_NEAR_THR
    } t_cfg_idx;

    typedef struct packed {
        logic [TRIG_W-1:0]    trig_low;
        logic [TRIG_W-1:0]    trig_high;
        logic [HOLD_W-1:0]    holdoff;
        logic [TIMEOUT_W-1:0] timeout;
        logic [DIST_W-1:0]    near_thr;
    } t_cfg;

    // One tick of the sequencer as seen by the result logic
    typedef struct packed {
        logic   drive;
        logic   oe;
        logic   busy;
        logic   valid;
        logic   tout;
        t_width width;
    } t_step;

    // Zero acts as one; clamp to what the counter can hold.
    function automatic t_count echo_limit(input logic [TIMEOUT_W-1:0] timeout);
        int unsigned lim;
        lim = (timeout == '0) ? 32'd1 : 32'(timeout);
        if (lim > 32'(CNT_MAX)) begin
            lim = 32'(CNT_MAX);
        end
        return lim[COUNT_WIDTH-1:0];
    endfunction

endpackage

// ----- src/upr_seq.sv -----
// Trigger and echo sequencer: phase and tick counter, one step per word.
module upr_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_start,
    input  logic             i_echo,
    input  upr_pkg::t_cfg    i_cfg,
    output upr_pkg::t_step   o_step
);

    upr_pkg::t_phase r_phase, n_phase;
    upr_pkg::t_count r_tick, n_tick;

    upr_pkg::t_phase s_phase;
    upr_pkg::t_count s_tick;
    upr_pkg::t_count s_lim;
    logic [upr_pkg::COUNT_WIDTH:0] s_inc;

    assign s_lim = upr_pkg::echo_limit(i_cfg.timeout);
    assign s_inc = {1'b0, s_tick} + (upr_pkg::COUNT_WIDTH + 1)'(1);

    // Resolve the phase for this tick: take a start, pass zero-length phases.
    always_comb begin
        s_phase = r_phase;
        s_tick  = r_tick;
        unique case (r_phase)
            upr_pkg::PH_IDLE: begin
                if (i_start) begin
                    s_phase = upr_pkg::PH_PRELOW;
                    s_tick  = '0;
                end
            end
            upr_pkg::PH_PRELOW, upr_pkg::PH_HIGH, upr_pkg::PH_HOLD, upr_pkg::PH_ECHO: begin
                s_phase = r_phase;
            end
            default: begin
                s_phase = i_start ? upr_pkg::PH_PRELOW : upr_pkg::PH_IDLE;
                s_tick  = i_start ? '0 : r_tick;
            end
        endcase
        if (s_phase == upr_pkg::PH_PRELOW &&
            s_tick >= upr_pkg::COUNT_WIDTH'(i_cfg.trig_low)) begin
            s_phase = upr_pkg::PH_HIGH;
            s_tick  = '0;
        end
        if (s_phase == upr_pkg::PH_HIGH &&
            s_tick >= upr_pkg::COUNT_WIDTH'(i_cfg.trig_high)) begin
            s_phase = upr_pkg::PH_HOLD;
            s_tick  = '0;
        end
        if (s_phase == upr_pkg::PH_HOLD &&
            s_tick >= upr_pkg::COUNT_WIDTH'(i_cfg.holdoff)) begin
            s_phase = upr_pkg::PH_ECHO;
            s_tick  = '0;
        end
    end

    // Next state
    always_comb begin
        n_phase = s_phase;
        n_tick  = s_tick;
        unique case (s_phase)
            upr_pkg::PH_IDLE: begin
                n_tick = s_tick;
            end
            upr_pkg::PH_PRELOW, upr_pkg::PH_HIGH, upr_pkg::PH_HOLD: begin
                n_tick = s_inc[upr_pkg::COUNT_WIDTH-1:0];
            end
            upr_pkg::PH_ECHO: begin
                if (!i_echo || s_inc >= {1'b0, s_lim}) begin
                    n_phase = upr_pkg::PH_IDLE;
                    n_tick  = '0;
                end else begin
                    n_tick = s_inc[upr_pkg::COUNT_WIDTH-1:0];
                end
            end
            default: begin
                n_phase = upr_pkg::PH_IDLE;
                n_tick  = '0;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_step       = '0;
        o_step.busy  = (n_phase != upr_pkg::PH_IDLE);
        unique case (s_phase)
            upr_pkg::PH_IDLE: begin
                o_step.oe = 1'b0;
            end
            upr_pkg::PH_PRELOW, upr_pkg::PH_HOLD: begin
                o_step.oe = 1'b1;
            end
            upr_pkg::PH_HIGH: begin
                o_step.oe    = 1'b1;
                o_step.drive = 1'b1;
            end
            upr_pkg::PH_ECHO: begin
                if (!i_echo) begin
                    o_step.valid = 1'b1;
                    o_step.width = upr_pkg::WIDTH_W'(s_tick);
                end else if (s_inc >= {1'b0, s_lim}) begin
                    o_step.valid = 1'b1;
                    o_step.tout  = 1'b1;
                    o_step.width = upr_pkg::WIDTH_W'(s_lim);
                end
            end
            default: begin
                o_step.oe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upr_pkg::PH_IDLE;
            r_tick  <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
        end
    end

endmodule

// ----- src/upr_dist.sv -----
// Last measurement store: echo width, scaled distance and near compare.
module upr_dist (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  upr_pkg::t_step  i_step,
    input  upr_pkg::t_dist  i_near_thr,
    output upr_pkg::t_width o_width,
    output upr_pkg::t_dist  o_distance,
    output logic            o_near
);

    upr_pkg::t_width r_width, n_width;
    upr_pkg::t_dist  r_dist, n_dist;

    logic [upr_pkg::PROD_W-1:0] s_prod;

    // Half the round-trip width times the Q10 scale
    assign s_prod = upr_pkg::PROD_W'(i_step.width[upr_pkg::WIDTH_W-1:1]) *
                    upr_pkg::PROD_W'(upr_pkg::DIST_MULT);

    always_comb begin
        n_width = r_width;
        n_dist  = r_dist;
        if (i_step.valid) begin
            n_width = i_step.width;
            n_dist  = s_prod[upr_pkg::DIST_SHIFT +: upr_pkg::DIST_W];
        end
    end

    assign o_width    = n_width;
    assign o_distance = n_dist;
    assign o_near     = (n_dist < i_near_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= '0;
            r_dist  <= '0;
        end else if (i_adv) begin
            r_width <= n_width;
            r_dist  <= n_dist;
        end
    end

endmodule

// ----- src/ultrasonic_ping_ranger_core.sv -----
// Top level of the ultrasonic ranger: config registers, input and result stages.
//
// One input word per microsecond tick carries a start request and the sampled
// pin level; every accepted word yields exactly one result word describing the
// pin drive, busy state and, on completion, echo width and distance in 1/64 cm.
// Throughput is one word per clock while the receiver keeps m_axis_tready high;
// an accepted word passes the input register, then the result register, before
// it can be taken. The single-pass sequencer step and the 14x12 distance
// multiplier sit between the two registers.
// Configuration registers may be written only while no measurement is running
// and no word is in flight.
module ultrasonic_ping_ranger_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [upr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [upr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] start_req, [1] echo_level, [7:2] zero
    input  logic [upr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] pin_drive, [1] pin_output_enable, [2] busy_res, [3] result_valid,
    // [18:4] echo_width, [34:19] distance, [35] near, [36] timed_out, [39:37] zero
    output logic [upr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    upr_pkg::t_cfg r_cfg;

    logic r_in_valid;
    logic r_in_start;
    logic r_in_echo;
    logic r_out_valid;
    logic [upr_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [upr_pkg::OUT_TDATA_W-1:0] n_out_data;

    logic s_adv;
    logic s_in_take;

    upr_pkg::t_step  s_step;
    upr_pkg::t_width s_width;
    upr_pkg::t_dist  s_dist;
    logic            s_near;

    // Advance the held word whenever the result slot is free or draining.
    assign s_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || !r_out_valid || m_axis_tready;
    assign s_in_take     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_low  <= upr_pkg::RST_TRIG_LOW;
            r_cfg.trig_high <= upr_pkg::RST_TRIG_HIGH;
            r_cfg.holdoff   <= upr_pkg::RST_HOLDOFF;
            r_cfg.timeout   <= upr_pkg::RST_TIMEOUT;
            r_cfg.near_thr  <= upr_pkg::RST_NEAR_THR;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                upr_pkg::CFG_TRIG_LOW: begin
                    r_cfg.trig_low <= i_cfg_wdata[upr_pkg::TRIG_W-1:0];
                end
                upr_pkg::CFG_TRIG_HIGH: begin
                    r_cfg.trig_high <= i_cfg_wdata[upr_pkg::TRIG_W-1:0];
                end
                upr_pkg::CFG_HOLDOFF: begin
                    r_cfg.holdoff <= i_cfg_wdata[upr_pkg::HOLD_W-1:0];
                end
                upr_pkg::CFG_TIMEOUT: begin
                    r_cfg.timeout <= i_cfg_wdata[upr_pkg::TIMEOUT_W-1:0];
                end
                upr_pkg::CFG_NEAR_THR: begin
                    r_cfg.near_thr <= i_cfg_wdata[upr_pkg::DIST_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_in_take) begin
            r_in_valid <= 1'b1;
        end else if (s_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in_start <= s_axis_tdata[0];
            r_in_echo  <= s_axis_tdata[1];
        end
    end

    upr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s_adv),
        .i_start (r_in_start),
        .i_echo  (r_in_echo),
        .i_cfg   (r_cfg),
        .o_step  (s_step)
    );

    upr_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (s_adv),
        .i_step     (s_step),
        .i_near_thr (r_cfg.near_thr),
        .o_width    (s_width),
        .o_distance (s_dist),
        .o_near     (s_near)
    );

    assign n_out_data = {{upr_pkg::OB_PAD_W{1'b0}}, s_step.tout, s_near, s_dist, s_width,
                         s_step.valid, s_step.busy, s_step.oe, s_step.drive};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- src/upr_checker.sv -----
// Port-level checks of the ultrasonic ranger and their binding.
`include "assert_macros.svh"

module upr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [upr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic s_valid_res;
    logic s_tout;

    assign s_valid_res = m_axis_tvalid && m_axis_tdata[upr_pkg::OB_VALID];
    assign s_tout      = m_axis_tvalid && m_axis_tdata[upr_pkg::OB_TOUT];

    // A completing word ends the sequence and releases the pin.
    `UPR_ASSERT(a_done_not_busy, s_valid_res |-> (!m_axis_tdata[upr_pkg::OB_BUSY] && !m_axis_tdata[upr_pkg::OB_OE]), "completion word still busy or driving")
    `UPR_ASSERT(a_tout_is_result, s_tout |-> (m_axis_tdata[upr_pkg::OB_VALID] && (m_axis_tdata[upr_pkg::OB_WIDTH_LO +: upr_pkg::WIDTH_W] != '0)), "timeout without a nonzero result")
    `UPR_ASSERT(a_drive_needs_oe, (m_axis_tvalid && m_axis_tdata[upr_pkg::OB_DRIVE]) |-> m_axis_tdata[upr_pkg::OB_OE], "pin driven high while released")
    `UPR_ASSERT(a_idle_quiet, (m_axis_tvalid && !m_axis_tdata[upr_pkg::OB_BUSY] && !m_axis_tdata[upr_pkg::OB_VALID]) |-> (m_axis_tdata[upr_pkg::OB_OE] == 1'b0), "idle word drives the pin")
    `UPR_ASSERT_HOLD(a_stall_hold, (m_axis_tvalid && !m_axis_tready), {m_axis_tvalid, m_axis_tdata}, "stalled result word changed")

endmodule

bind ultrasonic_ping_ranger_core upr_checker u_upr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb_ultrasonic_ping_ranger_core.sv -----
// Self-checking testbench of the ultrasonic ranger core: directed table, then random stream.
`timescale 1ns / 1ps

module tb_ultrasonic_ping_ranger_core;
    import upr_pkg::*;

    localparam int unsigned SCALE_Q10    = 2228;
    localparam int unsigned RANDOM_WORDS = 920;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned PRINT_CAP    = 50;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = '1;

    typedef struct packed {
        logic   drive;
        logic   oe;
        logic   busy;
        logic   valid;
        t_width width;
        t_dist  distance;
        logic   near;
        logic   tout;
    } t_tick_result;

    typedef enum logic {
        ROW_WORD,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic                   start;
        logic                   echo;
        logic                   typed;
        t_tick_result           want;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
    } t_plan_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    // ranger state as predicted
    t_cfg        model_cfg;
    t_phase      seq_phase;
    int unsigned tick_cnt;
    t_width      held_width;
    t_dist       held_dist;

    t_tick_result pending_ticks[$];
    t_plan_row    plan[$];
    int unsigned  mismatch_count;
    int unsigned  words_sent;
    bit           tx_steady;
    bit           rx_steady;

    ultrasonic_ping_ranger_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void close_echo(input int unsigned w);
        int unsigned half;
        held_width = t_width'(w);
        half       = held_width >> 1;
        held_dist  = t_dist'((half * SCALE_Q10) >> 10);
        seq_phase  = PH_IDLE;
        tick_cnt   = 0;
    endfunction

    // Advance the ranger by one microsecond tick and return the word it emits.
    function automatic t_tick_result step_ranger(input logic start, input logic echo);
        t_tick_result r;
        int unsigned  need;
        int unsigned  lim;
        r = '0;
        if (start && seq_phase == PH_IDLE) begin
            seq_phase = PH_PRELOW;
            tick_cnt  = 0;
        end
        // zero-length trigger stages fall through within the same tick
        while (seq_phase == PH_PRELOW || seq_phase == PH_HIGH || seq_phase == PH_HOLD) begin
            case (seq_phase)
                PH_PRELOW: need = model_cfg.trig_low;
                PH_HIGH:   need = model_cfg.trig_high;
                default:   need = model_cfg.holdoff;
            endcase
            if (tick_cnt < need) break;
            seq_phase = (seq_phase == PH_PRELOW) ? PH_HIGH :
                        (seq_phase == PH_HIGH)   ? PH_HOLD : PH_ECHO;
            tick_cnt  = 0;
        end
        case (seq_phase)
            PH_PRELOW, PH_HOLD: begin
                r.oe = 1'b1;
                tick_cnt++;
            end
            PH_HIGH: begin
                r.oe    = 1'b1;
                r.drive = 1'b1;
                tick_cnt++;
            end
            PH_ECHO: begin
                lim = (model_cfg.timeout == '0) ? 1 : model_cfg.timeout;
                if (lim > CNT_MAX) lim = CNT_MAX;
                if (!echo) begin
                    close_echo(tick_cnt);
                    r.valid = 1'b1;
                end else begin
                    tick_cnt++;
                    if (tick_cnt >= lim) begin
                        close_echo(lim);
                        r.valid = 1'b1;
                        r.tout  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.busy     = (seq_phase != PH_IDLE);
        r.width    = held_width;
        r.distance = held_dist;
        r.near     = (held_dist < model_cfg.near_thr);
        return r;
    endfunction

    function automatic void add_word(input logic start, input logic echo);
        t_plan_row r;
        r       = '0;
        r.kind  = ROW_WORD;
        r.start = start;
        r.echo  = echo;
        plan.push_back(r);
    endfunction

    function automatic void add_typed(input logic start, input logic echo,
                                      input t_tick_result want);
        t_plan_row r;
        r       = '0;
        r.kind  = ROW_WORD;
        r.start = start;
        r.echo  = echo;
        r.typed = 1'b1;
        r.want  = want;
        plan.push_back(r);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        t_plan_row r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = data;
        plan.push_back(r);
    endfunction

    task automatic drive_tick(input logic start, input logic echo,
                              input logic typed, input t_tick_result want);
        int unsigned  gap;
        t_tick_result calc;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-2){1'b0}}, echo, start};
        do @(posedge i_clk); while (!s_axis_tready);
        calc = step_ranger(start, echo);
        pending_ticks.push_back(typed ? want : calc);
        words_sent++;
    endtask

    task automatic tick(input logic start, input logic echo);
        drive_tick(start, echo, 1'b0, '0);
    endtask

    // Finish any running measurement, then hold off until the pipe is empty.
    task automatic settle();
        while (seq_phase != PH_IDLE) tick(1'b0, 1'b0);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_ticks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TRIG_LOW:  model_cfg.trig_low  = data[TRIG_W-1:0];
            CFG_TRIG_HIGH: model_cfg.trig_high = data[TRIG_W-1:0];
            CFG_HOLDOFF:   model_cfg.holdoff   = data[HOLD_W-1:0];
            CFG_TIMEOUT:   model_cfg.timeout   = data[TIMEOUT_W-1:0];
            CFG_NEAR_THR:  model_cfg.near_thr  = data[DIST_W-1:0];
            default: ;
        endcase
    endtask

    // Write a register, sometimes with junk above its width.
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input int unsigned value, input int unsigned w);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        if (w < CFG_DATA_W && $urandom_range(0, 1) == 1)
            data = data | CFG_DATA_W'($urandom() << w);
        write_reg(idx, data);
    endtask

    // One measurement: start, trigger ticks with random echo, high run, then low.
    task automatic run_echo(input int unsigned high_len);
        int unsigned lead;
        int unsigned k;
        lead = model_cfg.trig_low + model_cfg.trig_high + model_cfg.holdoff;
        for (k = 0; k < lead + high_len + 1; k++) begin
            tick((k == 0) ? 1'b1 : 1'($urandom_range(0, 7) == 0),
                 (k < lead) ? 1'($urandom_range(0, 1)) : 1'(k < lead + high_len));
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            if (mismatch_count < PRINT_CAP)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_tick_result want;
        t_tick_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.drive    = m_axis_tdata[OB_DRIVE];
            got.oe       = m_axis_tdata[OB_OE];
            got.busy     = m_axis_tdata[OB_BUSY];
            got.valid    = m_axis_tdata[OB_VALID];
            got.width    = m_axis_tdata[OB_WIDTH_LO +: WIDTH_W];
            got.distance = m_axis_tdata[OB_DIST_LO +: DIST_W];
            got.near     = m_axis_tdata[OB_NEAR];
            got.tout     = m_axis_tdata[OB_TOUT];
            if (pending_ticks.size() == 0) begin
                if (mismatch_count < PRINT_CAP)
                    $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_ticks.pop_front();
                check_field("pin_drive", 32'(want.drive), 32'(got.drive));
                check_field("pin_output_enable", 32'(want.oe), 32'(got.oe));
                check_field("busy", 32'(want.busy), 32'(got.busy));
                check_field("result_valid", 32'(want.valid), 32'(got.valid));
                check_field("echo_width", 32'(want.width), 32'(got.width));
                check_field("distance", 32'(want.distance), 32'(got.distance));
                check_field("near", 32'(want.near), 32'(got.near));
                check_field("timed_out", 32'(want.tout), 32'(got.tout));
            end
        end
    end

    // Receiver: random stalls, with steady stretches now and then.
    initial begin : sink_side
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 499) == 0) rx_steady = !rx_steady;
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_tick_result at_rest;
        t_tick_result low_at_once;
        t_tick_result zero_timeout;
        int unsigned  lim;
        int unsigned  high_len;
        int unsigned  target;

        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        mismatch_count = 0;
        words_sent     = 0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;

        model_cfg.trig_low  = 8'd2;
        model_cfg.trig_high = 8'd5;
        model_cfg.holdoff   = 12'd750;
        model_cfg.timeout   = 15'd18500;
        model_cfg.near_thr  = 16'd1440;
        seq_phase  = PH_IDLE;
        tick_cnt   = 0;
        held_width = '0;
        held_dist  = '0;

        at_rest       = '0;
        at_rest.near  = 1'b1;
        low_at_once       = at_rest;
        low_at_once.valid = 1'b1;
        zero_timeout       = low_at_once;
        zero_timeout.width = t_width'(1);
        zero_timeout.tout  = 1'b1;

        // after reset: idle, nothing measured, distance 0 below the default threshold
        add_typed(1'b0, 1'b0, at_rest);
        add_write(CFG_TRIG_LOW, 16'd0);
        add_write(CFG_TRIG_HIGH, 16'd0);
        add_write(CFG_HOLDOFF, 16'd0);
        add_write(CFG_TIMEOUT, 16'd0);
        // no trigger stages: echo sampled on the start tick, already low
        add_typed(1'b1, 1'b0, low_at_once);
        // zero timeout acts as one
        add_typed(1'b1, 1'b1, zero_timeout);
        add_word(1'b0, 1'b1);
        add_write(CFG_TIMEOUT, 16'd32767);
        add_write(CFG_NEAR_THR, 16'd0);
        add_write(CFG_TRIG_LOW, 16'd1);
        add_write(CFG_TRIG_HIGH, 16'd2);
        add_write(CFG_HOLDOFF, 16'd1);
        // short sequence; starts while busy and on the completing tick are dropped
        add_word(1'b1, 1'b1);
        add_word(1'b1, 1'b0);
        add_word(1'b0, 1'b1);
        add_word(1'b0, 1'b1);
        add_word(1'b0, 1'b1);
        add_word(1'b1, 1'b1);
        add_word(1'b1, 1'b0);
        add_word(1'b0, 1'b0);
        add_write(CFG_NEAR_THR, 16'hFFFF);
        add_write(CFG_UNMAPPED, 16'hFFFF);
        add_word(1'b0, 1'b0);
        add_write(CFG_NEAR_THR, 16'd35647);
        add_word(1'b0, 1'b0);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (i == 0 || plan[i-1].kind != ROW_WRITE) settle();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                drive_tick(plan[i].start, plan[i].echo, plan[i].typed, plan[i].want);
            end
        end

        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            settle();
            tx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
                write_setting(CFG_TRIG_LOW, ($urandom_range(0, 7) == 0) ?
                              $urandom_range(0, 255) : $urandom_range(0, 4), TRIG_W);
            if ($urandom_range(0, 3) != 0)
                write_setting(CFG_TRIG_HIGH, ($urandom_range(0, 7) == 0) ?
                              $urandom_range(0, 255) : $urandom_range(0, 4), TRIG_W);
            if ($urandom_range(0, 3) != 0)
                write_setting(CFG_HOLDOFF, ($urandom_range(0, 7) == 0) ?
                              $urandom_range(0, 400) : $urandom_range(0, 12), HOLD_W);
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_setting(CFG_TIMEOUT, 0, TIMEOUT_W);
                    1:       write_setting(CFG_TIMEOUT, 1, TIMEOUT_W);
                    2:       write_setting(CFG_TIMEOUT, 32767, TIMEOUT_W);
                    3:       write_setting(CFG_TIMEOUT, $urandom_range(100, 300), TIMEOUT_W);
                    default: write_setting(CFG_TIMEOUT, $urandom_range(2, 40), TIMEOUT_W);
                endcase
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       write_setting(CFG_NEAR_THR, 0, DIST_W);
                    1:       write_setting(CFG_NEAR_THR, 16'hFFFF, DIST_W);
                    2:       write_setting(CFG_NEAR_THR, 35647, DIST_W);
                    3:       write_setting(CFG_NEAR_THR, $urandom_range(0, 65535), DIST_W);
                    default: write_setting(CFG_NEAR_THR, $urandom_range(0, 60), DIST_W);
                endcase
            end
            if ($urandom_range(0, 15) == 0)
                write_setting(CFG_UNMAPPED, $urandom_range(0, 65535), CFG_DATA_W);

            lim = (model_cfg.timeout == '0) ? 1 : model_cfg.timeout;
            repeat ($urandom_range(2, 8)) begin
                if (words_sent < target) begin
                    // noise between measurements, now and then a stray start
                    repeat ($urandom_range(0, 5))
                        tick(1'($urandom_range(0, 9) == 0), 1'($urandom_range(0, 1)));
                    while (seq_phase != PH_IDLE) tick(1'b0, 1'b0);
                    case ($urandom_range(0, 7))
                        0: high_len = 0;
                        1: high_len = (lim <= 2000) ? lim + $urandom_range(0, 3) : 5;
                        2: high_len = (lim <= 2000) ? lim - 1 : 7;
                        default: high_len = $urandom_range(1, (lim < 60) ? lim : 60);
                    endcase
                    run_echo(high_len);
                end
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
